// ===== rtl/stable_insertion_sorter_defines.svh =====
// Assertion macros used by the sorter RTL.
`ifndef STABLE_INSERTION_SORTER_DEFINES_SVH
`define STABLE_INSERTION_SORTER_DEFINES_SVH

// Check that a condition implies a consequence in the next cycle.
`define SIS_ASSERT_NEXT(label, clk, rst, cond, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (cons)) \
      else $error("sorter check failed in the cycle after the trigger");

// Check that a condition implies a consequence in the same cycle.
`define SIS_ASSERT_SAME(label, clk, rst, cond, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (cons)) \
      else $error("sorter check failed");

`endif

// ===== rtl/sis_pkg.sv =====
package sis_pkg;

   localparam int DATA_W = 32;

   typedef logic signed [DATA_W-1:0] sis_data_type;

   typedef enum logic {
      SIS_FILL,
      SIS_DRAIN
   } sis_state_type;

   typedef struct packed {
      logic insert;
      logic shift_down;
   } sis_cmd_type;

endpackage

// ===== rtl/sis_cell.sv =====
module sis_cell
   import sis_pkg::*;
(
   input  logic         clock,
   input  sis_cmd_type  cmd,
   input  sis_data_type new_value,
   input  logic         occupied,
   input  logic         prev_after,
   input  sis_data_type prev_value,
   input  sis_data_type next_value,
   output sis_data_type value,
   output logic         after
);

   sis_data_type value_ff;
   sis_data_type value_in;

   always_comb begin
      after = !occupied || (value_ff > new_value);
   end

   always_comb begin
      priority if (cmd.shift_down) begin
         value_in = next_value;
      end else if (cmd.insert && prev_after) begin
         value_in = prev_value;
      end else if (cmd.insert && after) begin
         value_in = new_value;
      end else begin
         value_in = value_ff;
      end
   end

   always_ff @(posedge clock) begin
      value_ff <= value_in;
   end

   assign value = value_ff;

endmodule

// ===== rtl/stable_insertion_sorter.sv =====
// Insertion: one input transfer per cycle while filling; a value lands in the cell chain
// at the next edge unless the store is full; then it is dropped and the overflow
// flag is set. After the last item, results start in the next cycle, one per cycle
// while rsp_tready is high, as the chain shifts toward cell 0; no input is taken
// while draining. CAPACITY sets the chain length.
// Reset (synchronous, active high) empties the store and clears the overflow flag;
// cell contents are not reset.
`include "stable_insertion_sorter_defines.svh"

module stable_insertion_sorter
   import sis_pkg::*;
#(
   parameter int CAPACITY = 16
)
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,  // [31:0] value
   input  logic        req_tlast,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,  // [31:0] sorted_value
   output logic        rsp_tlast,
   output logic        rsp_tuser   // [0] overflow
);

   localparam int CNT_W = $clog2(CAPACITY + 1);

   sis_state_type   state_ff;
   sis_state_type   state_in;
   logic [CNT_W-1:0] count_ff;
   logic [CNT_W-1:0] count_in;
   logic            dropped_ff;
   logic            dropped_in;

   logic            req_fire;
   logic            rsp_fire;
   logic            full;
   sis_cmd_type     cmd;
   sis_data_type    new_value;

   sis_data_type    cell_value [CAPACITY];
   logic            cell_after [CAPACITY];
   logic            cell_occ   [CAPACITY];

   assign new_value = sis_data_type'(req_tdata);
   assign full      = (count_ff == CNT_W'(CAPACITY));
   assign req_fire  = req_tvalid && req_tready;
   assign rsp_fire  = rsp_tvalid && rsp_tready;

   always_comb begin
      cmd.insert     = req_fire && !full;
      cmd.shift_down = rsp_fire;
   end

   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      sis_data_type prev_value;
      sis_data_type next_value;
      logic         prev_after;

      assign cell_occ[i] = (count_ff > CNT_W'(i));

      if (i == 0) begin : g_head
         assign prev_value = new_value;
         assign prev_after = 1'b0;
      end else begin : g_body
         assign prev_value = cell_value[i-1];
         assign prev_after = cell_after[i-1];
      end

      if (i == CAPACITY - 1) begin : g_tail
         assign next_value = cell_value[i];
      end else begin : g_inner
         assign next_value = cell_value[i+1];
      end

      sis_cell u_cell (
         .clock      (clock),
         .cmd        (cmd),
         .new_value  (new_value),
         .occupied   (cell_occ[i]),
         .prev_after (prev_after),
         .prev_value (prev_value),
         .next_value (next_value),
         .value      (cell_value[i]),
         .after      (cell_after[i])
      );
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         SIS_FILL: begin
            if (req_fire && req_tlast) begin
               state_in = SIS_DRAIN;
            end
         end
         SIS_DRAIN: begin
            if (rsp_fire && rsp_tlast) begin
               state_in = SIS_FILL;
            end
         end
         default: state_in = SIS_FILL;
      endcase
   end

   always_comb begin
      count_in   = count_ff;
      dropped_in = dropped_ff;
      if (cmd.insert) begin
         count_in = count_ff + CNT_W'(1);
      end
      if (req_fire && full) begin
         dropped_in = 1'b1;
      end
      if (rsp_fire) begin
         count_in = count_ff - CNT_W'(1);
         if (rsp_tlast) begin
            dropped_in = 1'b0;
         end
      end
   end

   always_comb begin
      req_tready = (state_ff == SIS_FILL);
      rsp_tvalid = (state_ff == SIS_DRAIN);
      rsp_tdata  = 32'(cell_value[0]);
      rsp_tlast  = (count_ff == CNT_W'(1));
      rsp_tuser  = dropped_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= SIS_FILL;
         count_ff   <= '0;
         dropped_ff <= 1'b0;
      end else begin
         state_ff   <= state_in;
         count_ff   <= count_in;
         dropped_ff <= dropped_in;
      end
   end

   `SIS_ASSERT_SAME(a_drain_not_empty, clock, reset, state_ff == SIS_DRAIN, count_ff != '0)
   `SIS_ASSERT_NEXT(a_drop_sets_flag, clock, reset, req_fire && full, dropped_ff)
   `SIS_ASSERT_NEXT(a_last_starts_drain, clock, reset, req_fire && req_tlast, state_ff == SIS_DRAIN)
   `SIS_ASSERT_NEXT(a_final_result_empties, clock, reset, rsp_fire && rsp_tlast, state_ff == SIS_FILL && count_ff == '0 && !dropped_ff)

endmodule
